>>> hw/rtl/circle_outline_rasterizer_macros.svh
// Assertion macros for the circle outline rasterizer.
// Used by the top level; expects signals clk and rst in the including scope.
`ifndef CIRCLE_OUTLINE_RASTERIZER_MACROS_SVH
`define CIRCLE_OUTLINE_RASTERIZER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define COR_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("cor assertion failed");

// Next-cycle implication, checked outside reset.
`define COR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("cor assertion failed");

`endif

>>> hw/rtl/cor_pkg.sv
// Shared types and constants of the circle outline rasterizer.
// No dependencies; imported by every module of the block.
package cor_pkg;

  localparam int SCREEN_COLUMNS = 320;
  localparam int SCREEN_ROWS    = 240;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic FUNC_START = 1'b0;
  localparam logic FUNC_STEP  = 1'b1;

  // One iteration handed from the front to the back: the eight pixels of
  // position (a, b) around the saved center.
  typedef struct packed {
    logic signed [11:0] cx;
    logic signed [11:0] cy;
    logic [23:0]        color;
    logic [10:0]        a;
    logic [10:0]        b;
    logic               done;
  } iter_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

endpackage

>>> hw/rtl/cor_front.sv
// Front of the circle outline rasterizer: takes requests, keeps the circle
// state and pushes one iteration record per drawn step. Depends on cor_pkg.
module cor_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 in_func,
  input  logic signed [11:0]   in_center_x,
  input  logic signed [11:0]   in_center_y,
  input  logic [9:0]           in_radius,
  input  logic [23:0]          in_color,
  input  cor_pkg::queue_status_t q_status,
  output logic                 push,
  output cor_pkg::iter_t       push_item
);
  import cor_pkg::*;

  logic signed [11:0] saved_center_x;
  logic signed [11:0] saved_center_y;
  logic [23:0]        saved_color;
  logic [10:0]        step_offset_a;
  logic [10:0]        step_offset_b;
  logic [15:0]        decision_value;
  logic               drawing_active;

  logic        accept;
  logic        is_start;
  logic        d_pos;
  logic [15:0] diff4;
  logic [10:0] adv_a;
  logic [10:0] adv_b;
  logic [15:0] adv_d;
  logic [10:0] cur_a;
  logic [10:0] cur_b;
  logic [15:0] cur_d;
  logic        cur_pos;
  logic [12:0] next_a;
  logic [12:0] next_b;
  logic        done;
  logic        passed;
  logic        active_next;

  assign in_ready = !q_status.full;
  assign accept   = in_valid && in_ready;
  assign is_start = (in_func == FUNC_START);

  // One Bresenham circle iteration on the stored position.
  assign d_pos = !decision_value[15] && (decision_value != 16'd0);
  assign diff4 = ({5'b0, step_offset_a} - {5'b0, step_offset_b}) << 2;
  assign adv_a = step_offset_a + 11'd1;
  assign adv_b = d_pos ? (step_offset_b - 11'd1) : step_offset_b;
  assign adv_d = d_pos ? (decision_value + diff4 + 16'd10)
                       : (decision_value + {3'b0, step_offset_a, 2'b0} + 16'd6);

  assign cur_a = is_start ? 11'd0 : adv_a;
  assign cur_b = is_start ? {1'b0, in_radius} : adv_b;
  assign cur_d = is_start ? (16'd3 - {5'b0, in_radius, 1'b0}) : adv_d;

  // The circle ends on this position when the following one would have b < a.
  assign cur_pos = !cur_d[15] && (cur_d != 16'd0);
  assign next_a  = {2'b0, cur_a} + 13'd1;
  assign next_b  = {2'b0, cur_b} - {12'b0, cur_pos};
  assign done    = $signed(next_b) < $signed(next_a);
  assign passed  = cur_b < cur_a;

  assign push = accept && (is_start || (drawing_active && !passed));

  always_comb begin
    active_next = drawing_active;
    if (is_start) begin
      active_next = !done;
    end else if (drawing_active) begin
      active_next = !passed && !done;
    end
  end

  assign push_item.cx    = is_start ? in_center_x : saved_center_x;
  assign push_item.cy    = is_start ? in_center_y : saved_center_y;
  assign push_item.color = is_start ? in_color : saved_color;
  assign push_item.a     = cur_a;
  assign push_item.b     = cur_b;
  assign push_item.done  = done;

  always_ff @(posedge clk) begin
    if (rst) begin
      saved_center_x <= '0;
      saved_center_y <= '0;
      saved_color    <= '0;
      step_offset_a  <= '0;
      step_offset_b  <= '0;
      decision_value <= '0;
      drawing_active <= 1'b0;
    end else if (accept && (is_start || drawing_active)) begin
      if (is_start) begin
        saved_center_x <= in_center_x;
        saved_center_y <= in_center_y;
        saved_color    <= in_color;
      end
      step_offset_a  <= cur_a;
      step_offset_b  <= cur_b;
      decision_value <= cur_d;
      drawing_active <= active_next;
    end
  end

endmodule

>>> hw/rtl/cor_queue.sv
// Short queue of iteration records between front and back.
// Depends on cor_pkg for the record type and depth.
module cor_queue (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  cor_pkg::iter_t        push_item,
  input  logic                  pop,
  output cor_pkg::iter_t        head,
  output cor_pkg::queue_status_t status
);
  import cor_pkg::*;

  iter_t             slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              do_push;
  logic              do_pop;

  assign status.full  = (count == QCNT_W'(QUEUE_DEPTH));
  assign status.empty = (count == '0);
  assign do_push      = push && !status.full;
  assign do_pop       = pop && !status.empty;
  assign head         = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

>>> hw/rtl/cor_back.sv
// Back of the circle outline rasterizer: expands each iteration record into
// eight pixels, one per cycle while out_ready allows, through two registered stages. Depends on cor_pkg.
module cor_back (
  input  logic                   clk,
  input  logic                   rst,
  input  cor_pkg::queue_status_t q_status,
  input  cor_pkg::iter_t         q_head,
  output logic                   pop,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic signed [12:0]     pixel_x,
  output logic signed [12:0]     pixel_y,
  output logic                   on_screen,
  output logic [16:0]            pixel_address,
  output logic [23:0]            pixel_color,
  output logic                   last_of_step,
  output logic                   circle_done
);
  import cor_pkg::*;

  iter_t       cur;
  logic        busy;
  logic [2:0]  idx;

  logic        s1_valid;
  logic [12:0] s1_x;
  logic [12:0] s1_y;
  logic [23:0] s1_color;
  logic        s1_last;
  logic        s1_done;

  logic        m_adv;
  logic        s1_load;
  logic        gen_fire;
  logic        gen_last;
  logic [10:0] x_mag;
  logic [10:0] y_mag;
  logic [12:0] x_off;
  logic [12:0] y_off;
  logic [12:0] gen_x;
  logic [12:0] gen_y;
  logic        x_in;
  logic        y_in;
  logic        s2_on;
  logic [24:0] s2_prod;

  assign m_adv    = !out_valid || out_ready;
  assign s1_load  = !s1_valid || m_adv;
  assign gen_fire = busy && s1_load;
  assign gen_last = (idx == 3'd7);
  assign pop      = !q_status.empty && (!busy || (gen_fire && gen_last));

  // Octant order: the upper index bit swaps a and b, bit 0 mirrors x, bit 1 mirrors y.
  assign x_mag = idx[2] ? cur.b : cur.a;
  assign y_mag = idx[2] ? cur.a : cur.b;
  assign x_off = idx[0] ? (13'd0 - {2'b0, x_mag}) : {2'b0, x_mag};
  assign y_off = idx[1] ? (13'd0 - {2'b0, y_mag}) : {2'b0, y_mag};
  assign gen_x = {cur.cx[11], cur.cx} + x_off;
  assign gen_y = {cur.cy[11], cur.cy} + y_off;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= '0;
    end else if (!busy) begin
      if (pop) begin
        busy <= 1'b1;
        idx  <= '0;
      end
    end else if (gen_fire) begin
      idx <= idx + 3'd1;
      if (gen_last && !pop) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= q_head;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_load) begin
      s1_valid <= gen_fire;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1_x     <= gen_x;
      s1_y     <= gen_y;
      s1_color <= cur.color;
      s1_last  <= gen_last;
      s1_done  <= gen_last && cur.done;
    end
  end

  assign x_in    = !s1_x[12] && ({1'b0, s1_x} < 14'(SCREEN_COLUMNS));
  assign y_in    = !s1_y[12] && ({1'b0, s1_y} < 14'(SCREEN_ROWS));
  assign s2_on   = x_in && y_in;
  assign s2_prod = 25'(s1_y[11:0]) * 25'(SCREEN_COLUMNS) + 25'(s1_x[11:0]);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (m_adv) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (m_adv) begin
      pixel_x       <= s1_x;
      pixel_y       <= s1_y;
      on_screen     <= s2_on;
      pixel_address <= s2_on ? s2_prod[16:0] : 17'd0;
      pixel_color   <= s1_color;
      last_of_step  <= s1_last;
      circle_done   <= s1_done;
    end
  end

endmodule

>>> hw/rtl/circle_outline_rasterizer.sv
// Top level of the circle outline rasterizer: front, queue and back.
// Depends on cor_pkg, cor_front, cor_queue, cor_back and the assertion macros.
//
// Requests come in on the s_axis channel. tuser = 0 starts a circle from the
// center, radius and color in tdata; tuser = 1 advances the current circle by
// one iteration. Each drawing request yields eight pixels on m_axis, one per
// cycle, in the order (+a,+b) (-a,+b) (+a,-b) (-a,-b) (+b,+a) (-b,+a) (+b,-a)
// (-b,-a); tlast marks the eighth, tuser marks the eighth of the final one.
// An advance request with no circle in progress yields nothing.
// The single pixel output sets the throughput of drawing requests; a request that
// yields nothing pushes no record. A record passes from the queue through the
// back end's record register, the s1 stage and the output register.
// A two-entry queue parts front and back, so requests are taken while earlier
// pixels still drain. When m_axis stalls, the pixel pipeline holds and the
// queue fills; s_axis_tready falls once it is full.
// Reset clears the circle state (no circle in progress), empties the queue
// and drops m_axis_tvalid.
`include "circle_outline_rasterizer_macros.svh"
module circle_outline_rasterizer (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // tdata: center_x[11:0], center_y[23:12], radius[33:24], color[57:34], zero[63:58]
  input  logic [63:0] s_axis_tdata,
  // tuser: func[0]
  input  logic        s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // tdata: pixel_x[12:0], pixel_y[25:13], on_screen[26], pixel_address[43:27],
  //        pixel_color[67:44], zero[71:68]
  output logic [71:0] m_axis_tdata,
  // tuser: circle_done[0]
  output logic        m_axis_tuser,
  // tlast: last_of_step
  output logic        m_axis_tlast
);
  import cor_pkg::*;

  queue_status_t q_status;
  iter_t         push_item;
  iter_t         q_head;
  logic          push;
  logic          pop;

  logic signed [12:0] pixel_x;
  logic signed [12:0] pixel_y;
  logic               on_screen;
  logic [16:0]        pixel_address;
  logic [23:0]        pixel_color;

  cor_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (s_axis_tvalid),
    .in_ready    (s_axis_tready),
    .in_func     (s_axis_tuser),
    .in_center_x (s_axis_tdata[11:0]),
    .in_center_y (s_axis_tdata[23:12]),
    .in_radius   (s_axis_tdata[33:24]),
    .in_color    (s_axis_tdata[57:34]),
    .q_status    (q_status),
    .push        (push),
    .push_item   (push_item)
  );

  cor_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head      (q_head),
    .status    (q_status)
  );

  cor_back u_back (
    .clk           (clk),
    .rst           (rst),
    .q_status      (q_status),
    .q_head        (q_head),
    .pop           (pop),
    .out_valid     (m_axis_tvalid),
    .out_ready     (m_axis_tready),
    .pixel_x       (pixel_x),
    .pixel_y       (pixel_y),
    .on_screen     (on_screen),
    .pixel_address (pixel_address),
    .pixel_color   (pixel_color),
    .last_of_step  (m_axis_tlast),
    .circle_done   (m_axis_tuser)
  );

  assign m_axis_tdata = {4'b0, pixel_color, pixel_address, on_screen, pixel_y, pixel_x};

  // The final pixel of a circle is always the eighth of its iteration.
  `COR_ASSERT_NOW(a_done_on_last, m_axis_tvalid && m_axis_tuser, m_axis_tlast)
  // Off-screen pixels carry a zero address.
  `COR_ASSERT_NOW(a_off_addr_zero, m_axis_tvalid && !on_screen, pixel_address == 17'd0)
  // A full queue must hold off new requests.
  `COR_ASSERT_NOW(a_full_stalls, q_status.full, !s_axis_tready)
  // A pop from an empty queue must never be issued.
  `COR_ASSERT_NOW(a_pop_nonempty, pop, !q_status.empty)

endmodule

>>> verif/tb.sv
// Self-checking testbench of the circle outline rasterizer.
// Depends on cor_pkg and the circle_outline_rasterizer top level; start and
// advance requests are predicted pixel by pixel and compared on m_axis.
module tb;
  import cor_pkg::*;

  typedef struct {
    int x;
    int y;
    int on;
    int addr;
    int color;
    int last;
    int done;
  } pixel_t;

  class circle_pixel_model;
    int ctr_x;
    int ctr_y;
    int ink;
    int pos_a;
    int pos_b;
    int decision;
    bit drawing;
    pixel_t pending_pixels[$];
    int errors;

    function new();
      ctr_x = 0;
      ctr_y = 0;
      ink = 0;
      pos_a = 0;
      pos_b = 0;
      decision = 0;
      drawing = 1'b0;
      errors = 0;
    endfunction

    function void next_position(ref int a, ref int b, ref int d);
      if (d > 0) begin
        d = d + 4 * (a - b) + 10;
        b = b - 1;
      end else begin
        d = d + 4 * a + 6;
      end
      a = a + 1;
    endfunction

    // Queues the eight mirrored pixels of the current position.
    function void queue_octants();
      int na;
      int nb;
      int nd;
      int dx;
      int dy;
      bit fin;
      pixel_t p;
      na = pos_a;
      nb = pos_b;
      nd = decision;
      next_position(na, nb, nd);
      fin = (nb < na);
      for (int i = 0; i < 8; i++) begin
        case (i)
          0: begin dx = pos_a;  dy = pos_b;  end
          1: begin dx = -pos_a; dy = pos_b;  end
          2: begin dx = pos_a;  dy = -pos_b; end
          3: begin dx = -pos_a; dy = -pos_b; end
          4: begin dx = pos_b;  dy = pos_a;  end
          5: begin dx = -pos_b; dy = pos_a;  end
          6: begin dx = pos_b;  dy = -pos_a; end
          default: begin dx = -pos_b; dy = -pos_a; end
        endcase
        p.x = ctr_x + dx;
        p.y = ctr_y + dy;
        p.on = (p.x >= 0 && p.x < SCREEN_COLUMNS && p.y >= 0 && p.y < SCREEN_ROWS) ? 1 : 0;
        p.addr = p.on ? ((p.y * SCREEN_COLUMNS + p.x) & 'h1FFFF) : 0;
        p.color = ink;
        p.last = (i == 7) ? 1 : 0;
        p.done = (i == 7 && fin) ? 1 : 0;
        pending_pixels.push_back(p);
      end
      if (fin)
        drawing = 1'b0;
    endfunction

    // Takes one accepted request; returns the number of pixels it causes.
    function int take_request(logic func, logic signed [11:0] cx, logic signed [11:0] cy,
                              logic [9:0] r, logic [23:0] color);
      if (func == FUNC_START) begin
        ctr_x = int'(cx);
        ctr_y = int'(cy);
        ink = int'(color);
        pos_a = 0;
        pos_b = int'(r);
        decision = 3 - 2 * int'(r);
        drawing = 1'b1;
        queue_octants();
        return 8;
      end
      if (!drawing)
        return 0;
      next_position(pos_a, pos_b, decision);
      if (pos_b < pos_a) begin
        drawing = 1'b0;
        return 0;
      end
      queue_octants();
      return 8;
    endfunction

    function void compare_field(string name, int exp_v, int act_v);
      if (exp_v != act_v) begin
        $error("%s: expected %0d, actual %0d", name, exp_v, act_v);
        errors++;
      end
    endfunction

    function void check_pixel(logic [71:0] data, logic user, logic last);
      pixel_t p;
      if (pending_pixels.size() == 0) begin
        $error("pixel with no pending expectation: tdata %h", data);
        errors++;
        return;
      end
      p = pending_pixels.pop_front();
      compare_field("pixel_x", p.x, int'($signed(data[12:0])));
      compare_field("pixel_y", p.y, int'($signed(data[25:13])));
      compare_field("on_screen", p.on, int'(data[26]));
      compare_field("pixel_address", p.addr, int'(data[43:27]));
      compare_field("pixel_color", p.color, int'(data[67:44]));
      compare_field("last_of_step", p.last, int'(last));
      compare_field("circle_done", p.done, int'(user));
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata = '0;
  logic        s_axis_tuser = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [71:0] m_axis_tdata;
  logic        m_axis_tuser;
  logic        m_axis_tlast;

  circle_pixel_model model = new();

  int burst_left = 0;
  int sent_requests = 0;
  int stall_mode = 0;
  int mode_left = 0;
  int stall_tick = 0;

  circle_outline_rasterizer u_top (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // The pixel receiver switches at random between four stall patterns.
  always @(negedge clk) begin
    if (mode_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      mode_left = $urandom_range(20, 200);
    end else begin
      mode_left--;
    end
    stall_tick++;
    case (stall_mode)
      0: m_axis_tready = 1'b1;
      1: m_axis_tready = ($urandom_range(0, 3) != 0);
      2: m_axis_tready = ((stall_tick % 5) != 0);
      default: m_axis_tready = ($urandom_range(0, 1) != 0);
    endcase
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready)
      model.check_pixel(m_axis_tdata, m_axis_tuser, m_axis_tlast);
  end

  // Called just after a falling edge; returns just after the falling edge
  // that follows acceptance.
  task automatic send_request(logic func, logic [11:0] cx, logic [11:0] cy, logic [9:0] r,
                              logic [23:0] color);
    s_axis_tvalid = 1'b1;
    s_axis_tuser = func;
    s_axis_tdata = {6'd0, color, r, cy, cx};
    do
      @(posedge clk);
    while (!s_axis_tready);
    void'(model.take_request(func, cx, cy, r, color));
    sent_requests++;
    @(negedge clk);
  endtask

  task automatic send_circle(int cx, int cy, int r, int color);
    send_request(FUNC_START, 12'(cx), 12'(cy), 10'(r), 24'(color));
  endtask

  // Advance requests carry random, ignored payload.
  task automatic send_step();
    send_request(FUNC_STEP, 12'($urandom), 12'($urandom), 10'($urandom), 24'($urandom));
  endtask

  // Bursts of requests with random gaps; some bursts follow with no gap.
  task automatic pace();
    if (burst_left == 0) begin
      if ($urandom_range(0, 3) != 0) begin
        s_axis_tvalid = 1'b0;
        repeat ($urandom_range(1, 6)) @(negedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
  endtask

  task automatic wait_drained();
    s_axis_tvalid = 1'b0;
    while (model.pending_pixels.size() != 0)
      @(negedge clk);
  endtask

  initial begin
    int r;
    int cx;
    int cy;
    int steps;
    bit paused;
    paused = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed part: idle advance, zero radius, field extremes, abandoned
    // circles, screen corners and a full small circle.
    send_step();
    send_circle(0, 0, 0, 0);
    send_step();
    send_circle(-2048, -2048, 1023, 'hFFFFFF);
    send_step();
    send_step();
    send_circle(2047, 2047, 1023, 'hAAAAAA);
    send_step();
    send_circle(160, 120, 5, 'h123456);
    while (model.drawing)
      send_step();
    send_step();
    wait_drained();
    send_circle(0, 0, 3, 'h555555);
    while (model.drawing)
      send_step();
    send_circle(319, 239, 1, 'h0F0F0F);
    while (model.drawing)
      send_step();
    send_circle(-1, 240, 2, 'hF0F0F0);
    send_step();

    while (sent_requests < 120) begin
      if ($urandom_range(0, 9) == 0) begin
        pace();
        send_step();
      end
      r = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1023) : $urandom_range(0, 40);
      if ($urandom_range(0, 3) == 0) begin
        cx = $urandom_range(0, 4095) - 2048;
        cy = $urandom_range(0, 4095) - 2048;
      end else begin
        cx = $urandom_range(0, 420) - 50;
        cy = $urandom_range(0, 340) - 50;
      end
      pace();
      send_circle(cx, cy, r, $urandom_range(0, 'hFFFFFF));
      if (r > 60) begin
        steps = $urandom_range(0, 12);
        repeat (steps) begin
          pace();
          send_step();
        end
      end else if ($urandom_range(0, 9) < 7) begin
        while (model.drawing) begin
          pace();
          send_step();
        end
        repeat ($urandom_range(0, 2)) begin
          pace();
          send_step();
        end
      end else begin
        steps = $urandom_range(0, r);
        repeat (steps) begin
          pace();
          send_step();
        end
      end
      if (!paused && sent_requests > 60) begin
        wait_drained();
        paused = 1'b1;
      end
    end

    wait_drained();
    repeat (16) @(negedge clk);
    if (model.errors == 0 && model.pending_pixels.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #8000000;
    $display("== FAIL ==");
    $finish;
  end

endmodule

>>> sim.f
+incdir+hw/rtl
hw/rtl/cor_pkg.sv
hw/rtl/cor_front.sv
hw/rtl/cor_queue.sv
hw/rtl/cor_back.sv
hw/rtl/circle_outline_rasterizer.sv
verif/tb.sv
